@@ design/acm_pkg.sv @@
// shared types, widths and register indexes of the accelerometer calibration core
package acm_pkg;

  localparam int NUM_AXES        = 3;
  localparam int RAW_W           = 12;
  localparam int MILLI_W         = 23;
  localparam int MILLI           = 1000;
  localparam int DIV_W           = 22;
  localparam int SQ_W            = 2 * DIV_W;
  localparam int SUM_W           = SQ_W + 2;
  localparam int ROOT_W          = SUM_W / 2;
  localparam int LANE_STAGES     = DIV_W + 3;
  localparam int SQRT_STAGES     = ROOT_W + 1;
  localparam int STAGES          = LANE_STAGES + SQRT_STAGES;
  localparam int CFG_IDX_W       = 3;
  localparam logic [RAW_W-1:0] OFFSET_RST = 12'd2048;
  localparam logic [RAW_W-1:0] SCALE_RST  = 12'd400;

  typedef logic [RAW_W-1:0]          raw_t;
  typedef logic signed [MILLI_W-1:0] milli_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [STAGES-1:0]         stage_en_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_Z  = 3'd0,
    CFG_ZERO_Y  = 3'd1,
    CFG_ZERO_X  = 3'd2,
    CFG_SCALE_Z = 3'd3,
    CFG_SCALE_Y = 3'd4,
    CFG_SCALE_X = 3'd5
  } cfg_idx_t;

endpackage

@@ design/acm_lane.sv @@
// one axis lane: offset removal, scaling by 1000, pipelined divide, square
module acm_lane (
  input  logic                         clk,
  input  logic [acm_pkg::LANE_STAGES-1:0] en,
  input  acm_pkg::raw_t                raw,
  input  acm_pkg::raw_t                offset,
  input  acm_pkg::raw_t                scale,
  output acm_pkg::milli_t              accel,
  output acm_pkg::sq_t                 sq
);
  import acm_pkg::*;

  logic signed [RAW_W:0] diff;
  logic [RAW_W-1:0]      diff_mag;
  logic [DIV_W-1:0]      prod;

  logic [DIV_W-1:0] dq_r   [0:DIV_W];
  logic [RAW_W-1:0] rem_r  [0:DIV_W];
  logic             neg_r  [0:DIV_W];
  logic             zs_r   [0:DIV_W];
  logic [RAW_W:0]   t_s    [1:DIV_W];
  logic             ge_s   [1:DIV_W];
  logic [DIV_W-1:0] dq_nxt [1:DIV_W];
  logic [RAW_W-1:0] rem_nxt[1:DIV_W];

  milli_t           val_r;
  logic [DIV_W-1:0] mag_r;
  milli_t           accel_r;
  sq_t              sq_r;

  // signed difference and its magnitude times 1000
  always_comb begin
    diff     = $signed({1'b0, raw}) - $signed({1'b0, offset});
    diff_mag = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
    prod     = DIV_W'(diff_mag * 10'(MILLI));
  end

  // one quotient bit per divider stage
  always_comb begin
    for (int k = 1; k <= DIV_W; k++) begin
      t_s[k]     = {rem_r[k-1], dq_r[k-1][DIV_W-1]};
      ge_s[k]    = t_s[k] >= {1'b0, scale};
      rem_nxt[k] = ge_s[k] ? RAW_W'(t_s[k] - {1'b0, scale}) : t_s[k][RAW_W-1:0];
      dq_nxt[k]  = {dq_r[k-1][DIV_W-2:0], ge_s[k]};
    end
  end

  // prep stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dq_r[0]  <= prod;
      rem_r[0] <= '0;
      neg_r[0] <= diff[RAW_W];
      zs_r[0]  <= (scale == '0);
    end
  end

  // divider stages
  always_ff @(posedge clk) begin
    for (int k = 1; k <= DIV_W; k++) begin
      if (en[k]) begin
        dq_r[k]  <= dq_nxt[k];
        rem_r[k] <= rem_nxt[k];
        neg_r[k] <= neg_r[k-1];
        zs_r[k]  <= zs_r[k-1];
      end
    end
  end

  // sign restore and zero scale
  always_ff @(posedge clk) begin
    if (en[DIV_W+1]) begin
      if (zs_r[DIV_W]) begin
        val_r <= '0;
        mag_r <= '0;
      end else begin
        val_r <= neg_r[DIV_W] ? -$signed({1'b0, dq_r[DIV_W]})
                              : $signed({1'b0, dq_r[DIV_W]});
        mag_r <= dq_r[DIV_W];
      end
    end
  end

  // square
  always_ff @(posedge clk) begin
    if (en[DIV_W+2]) begin
      accel_r <= val_r;
      sq_r    <= mag_r * mag_r;
    end
  end

  assign accel = accel_r;
  assign sq    = sq_r;

endmodule

@@ design/acm_sqrt.sv @@
// merge stage: sum of lane squares and pipelined floor square root
module acm_sqrt (
  input  logic                          clk,
  input  logic [acm_pkg::SQRT_STAGES-1:0] en,
  input  acm_pkg::sq_t                  sq    [acm_pkg::NUM_AXES],
  input  acm_pkg::milli_t               acc_in[acm_pkg::NUM_AXES],
  output acm_pkg::milli_t               acc_out[acm_pkg::NUM_AXES],
  output logic [acm_pkg::ROOT_W-1:0]    root
);
  import acm_pkg::*;

  logic [SUM_W-1:0]  rad_r  [0:ROOT_W];
  logic [ROOT_W+1:0] rm_r   [0:ROOT_W];
  logic [ROOT_W-1:0] root_r [0:ROOT_W];
  milli_t            acc_r  [0:ROOT_W][NUM_AXES];
  logic [ROOT_W+3:0] pr_s   [1:ROOT_W];
  logic [ROOT_W+3:0] tr_s   [1:ROOT_W];
  logic              ge_s   [1:ROOT_W];

  // two radicand bits per stage against the trial root
  always_comb begin
    for (int j = 1; j <= ROOT_W; j++) begin
      pr_s[j] = {rm_r[j-1], rad_r[j-1][SUM_W-1 -: 2]};
      tr_s[j] = {2'b00, root_r[j-1], 2'b01};
      ge_s[j] = pr_s[j] >= tr_s[j];
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rad_r[0]  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      rm_r[0]   <= '0;
      root_r[0] <= '0;
      for (int a = 0; a < NUM_AXES; a++) acc_r[0][a] <= acc_in[a];
    end
  end

  // root stages
  always_ff @(posedge clk) begin
    for (int j = 1; j <= ROOT_W; j++) begin
      if (en[j]) begin
        rad_r[j]  <= {rad_r[j-1][SUM_W-3:0], 2'b00};
        rm_r[j]   <= ge_s[j] ? (ROOT_W+2)'(pr_s[j] - tr_s[j]) : pr_s[j][ROOT_W+1:0];
        root_r[j] <= {root_r[j-1][ROOT_W-2:0], ge_s[j]};
        for (int a = 0; a < NUM_AXES; a++) acc_r[j][a] <= acc_r[j-1][a];
      end
    end
  end

  assign root = root_r[ROOT_W];
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) acc_out[a] = acc_r[ROOT_W][a];
  end

endmodule

@@ design/accel_calibrate_magnitude_core.sv @@
// top level of the accelerometer calibration and magnitude core
//
// Input beats carry one raw Z/Y/X reading each; output beats carry the three
// calibrated axes in milli-g (truncated toward zero) and the floor square
// root of their summed squares. Configuration writes (index 0..5: zero
// offsets Z/Y/X, counts per g Z/Y/X) go over the cfg channel, which is
// always ready; indexes above five are dropped. Write only when idle.
// Three identical lanes each divide one bit per stage (22 stages), then a
// merge stage adds the squares and a 23 stage root pipeline finishes.
// One beat is accepted every cycle while the pipe has room.
// Every stage advances whenever the stage after it is empty or advancing,
// so with out_tready low the pipe keeps filling and input stalls only once
// all 49 stages hold beats. Reset empties the pipe and loads offsets of
// 2048 and 400 counts per g on every axis.
module accel_calibrate_magnitude_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [39:0]                   in_tdata,  // raw_z, raw_y, raw_x, zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [95:0]                   out_tdata, // accel_z, accel_y, accel_x, magnitude, pad
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acm_pkg::RAW_W-1:0]     cfg_data
);
  import acm_pkg::*;

  raw_t      offset_r [NUM_AXES];
  raw_t      scale_r  [NUM_AXES];
  raw_t      raw      [NUM_AXES];
  logic      vld_r    [STAGES];
  stage_en_t adv;
  milli_t    lane_acc [NUM_AXES];
  sq_t       lane_sq  [NUM_AXES];
  milli_t    res_acc  [NUM_AXES];
  logic [ROOT_W-1:0] res_root;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        offset_r[a] <= OFFSET_RST;
        scale_r[a]  <= SCALE_RST;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ZERO_Z:  offset_r[0] <= cfg_data;
        CFG_ZERO_Y:  offset_r[1] <= cfg_data;
        CFG_ZERO_X:  offset_r[2] <= cfg_data;
        CFG_SCALE_Z: scale_r[0]  <= cfg_data;
        CFG_SCALE_Y: scale_r[1]  <= cfg_data;
        CFG_SCALE_X: scale_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage advance chain from the output back
  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) adv[i] = !vld_r[i] || adv[i+1];
  end
  assign in_tready = adv[0];

  // beat valid per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) vld_r[i] <= 1'b0;
    end else begin
      if (adv[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < STAGES; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // axis lanes
  assign raw[0] = in_tdata[11:0];
  assign raw[1] = in_tdata[23:12];
  assign raw[2] = in_tdata[35:24];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    acm_lane u_lane (
      .clk    (clk),
      .en     (adv[LANE_STAGES-1:0]),
      .raw    (raw[a]),
      .offset (offset_r[a]),
      .scale  (scale_r[a]),
      .accel  (lane_acc[a]),
      .sq     (lane_sq[a])
    );
  end

  // merge and root
  acm_sqrt u_sqrt (
    .clk     (clk),
    .en      (adv[STAGES-1:LANE_STAGES]),
    .sq      (lane_sq),
    .acc_in  (lane_acc),
    .acc_out (res_acc),
    .root    (res_root)
  );

  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = {4'b0, res_root, res_acc[2], res_acc[1], res_acc[0]};

`ifndef ASSERT_OFF
  // input only stalls when stage 0, the merge stage and the last stage all hold beats
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (vld_r[0] && vld_r[LANE_STAGES] && vld_r[STAGES-1]))
    else $error("input stalled with empty stages");
  // nothing comes out right after reset
  assert property (@(posedge clk) (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("output valid right after reset");
  // magnitude covers the x axis value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed({1'b0, res_root}) >= res_acc[2]
                    && $signed({1'b0, res_root}) >= -res_acc[2]))
    else $error("magnitude below x axis value");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench of the accelerometer calibration and magnitude core
`timescale 1ns / 1ps

module testbench;
  import acm_pkg::*;

  localparam int LATENCY  = 49;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    raw_t raw_x;
    raw_t raw_y;
    raw_t raw_z;
  } reading_t;

  typedef struct {
    logic [MILLI_W-1:0] acc_z;
    logic [MILLI_W-1:0] acc_y;
    logic [MILLI_W-1:0] acc_x;
    logic [MILLI_W-1:0] mag;
  } milli_g_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RAW_W-1:0] cfg_data = '0;

  accel_calibrate_magnitude_core uut (.*);

  always #1 clk = ~clk;

  // predictor copy of the calibration registers
  raw_t zero_off[NUM_AXES];
  raw_t scale[NUM_AXES];

  reading_t pending_readings[$];
  milli_g_t expected_milli_g[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_send = 1'b0;
  bit in_fire = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic longint calib_axis(input raw_t raw, input raw_t off, input raw_t sc);
    longint diff;
    if (sc == 0) return 0;
    diff = longint'(raw) - longint'(off);
    return (diff * 1000) / longint'(sc);
  endfunction

  function automatic longint floor_sqrt(input longint v);
    longint r;
    longint b;
    r = 0;
    for (b = 23; b >= 0; b--)
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) r += (64'd1 << b);
    return r;
  endfunction

  function automatic milli_g_t predict_milli_g(input reading_t rd);
    milli_g_t m;
    longint z, y, x;
    longint root;
    z = calib_axis(rd.raw_z, zero_off[0], scale[0]);
    y = calib_axis(rd.raw_y, zero_off[1], scale[1]);
    x = calib_axis(rd.raw_x, zero_off[2], scale[2]);
    m.acc_z = z[MILLI_W-1:0];
    m.acc_y = y[MILLI_W-1:0];
    m.acc_x = x[MILLI_W-1:0];
    root = floor_sqrt(z * z + y * y + x * x);
    m.mag = root[MILLI_W-1:0];
    return m;
  endfunction

  // driver: present the next pending reading on the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (pending_readings.size() > 0 && !hold_send &&
          $urandom_range(99, 0) >= send_idle_pct) begin
        in_tdata <= {4'b0, pending_readings.pop_front()};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // monitor: predict on accepted input beats, check accepted output beats
  always @(posedge clk) begin
    milli_g_t want;
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_milli_g.push_back(predict_milli_g(reading_t'(in_tdata[35:0])));
      if (out_tvalid && out_tready) begin
        if (expected_milli_g.size() == 0) begin
          $display("mismatch: output beat with nothing expected");
          errors++;
        end else begin
          want = expected_milli_g.pop_front();
          if (out_tdata[22:0] !== want.acc_z)
            report("accel_z", $signed(out_tdata[22:0]), $signed(want.acc_z));
          if (out_tdata[45:23] !== want.acc_y)
            report("accel_y", $signed(out_tdata[45:23]), $signed(want.acc_y));
          if (out_tdata[68:46] !== want.acc_x)
            report("accel_x", $signed(out_tdata[68:46]), $signed(want.acc_x));
          if (out_tdata[91:69] !== want.mag)
            report("magnitude", out_tdata[91:69], want.mag);
        end
      end
      // watchdog on cycles without any accepted beat
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input raw_t val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= CFG_ZERO_X) zero_off[idx[1:0]] = val;
    else scale[2'(idx - CFG_SCALE_Z)] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_readings.size() > 0 || in_tvalid || expected_milli_g.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic queue_reading(input raw_t z, input raw_t y, input raw_t x);
    reading_t rd;
    rd.raw_z = z;
    rd.raw_y = y;
    rd.raw_x = x;
    pending_readings.push_back(rd);
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_reading(raw_t'($urandom), raw_t'($urandom), raw_t'($urandom));
  endtask

  initial begin
    int i;
    for (i = 0; i < NUM_AXES; i++) begin
      zero_off[i] = OFFSET_RST;
      scale[i] = SCALE_RST;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset calibration, field extremes
    queue_reading(12'd0, 12'd0, 12'd0);
    queue_reading(12'hFFF, 12'hFFF, 12'hFFF);
    queue_reading(12'd2048, 12'd2048, 12'd2048);
    queue_reading(12'd0, 12'hFFF, 12'd2048);
    queue_reading(12'd2447, 12'd1649, 12'd2049);
    queue_reading(12'hAAA, 12'h555, 12'h0F0);
    drain();

    // unit scale and extreme offsets give the largest outputs
    write_reg(CFG_ZERO_Z, 12'd0);
    write_reg(CFG_ZERO_Y, 12'hFFF);
    write_reg(CFG_ZERO_X, 12'd0);
    write_reg(CFG_SCALE_Z, 12'd1);
    write_reg(CFG_SCALE_Y, 12'd1);
    write_reg(CFG_SCALE_X, 12'd1);
    queue_reading(12'hFFF, 12'd0, 12'hFFF);
    queue_reading(12'd0, 12'hFFF, 12'd0);
    queue_reading(12'd1, 12'hFFE, 12'd7);
    drain();

    // zero scale forces that axis to zero
    write_reg(CFG_SCALE_Z, 12'd0);
    write_reg(CFG_SCALE_Y, 12'hFFF);
    write_reg(CFG_SCALE_X, 12'd0);
    queue_reading(12'hFFF, 12'd0, 12'hFFF);
    queue_reading(12'd3, 12'hFFF, 12'd0);
    queue_random(4);
    drain();

    // random phases over different idling mixes and settings
    for (i = 0; i < 7; i++) begin
      case (i % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      write_reg(CFG_ZERO_Z, raw_t'($urandom));
      write_reg(CFG_ZERO_Y, raw_t'($urandom));
      write_reg(CFG_ZERO_X, raw_t'($urandom));
      write_reg(CFG_SCALE_Z, (i == 6) ? 12'hFFF : raw_t'($urandom_range(4095, 1)));
      write_reg(CFG_SCALE_Y, raw_t'($urandom_range(4095, (i == 5) ? 0 : 1)));
      write_reg(CFG_SCALE_X, raw_t'($urandom_range(20, 1)));
      queue_random(100);
      if (i == 3) begin
        // sender holds off until every result is back
        wait (pending_readings.size() < 50);
        hold_send = 1'b1;
        while (in_tvalid || expected_milli_g.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

@@ accel_calibrate_magnitude_core.f @@
design/acm_pkg.sv
design/acm_lane.sv
design/acm_sqrt.sv
design/accel_calibrate_magnitude_core.sv
tb/sv/testbench.sv
